/* hdl/sprite_quad_corner_setup_top_defines.svh */
// assertion macros for the sprite quad corner setup block
`ifndef SPRITE_QUAD_CORNER_SETUP_TOP_DEFINES_SVH
`define SPRITE_QUAD_CORNER_SETUP_TOP_DEFINES_SVH
// implication checked on every edge out of reset
`define SQC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqc check failed");
// implication checked in the next cycle
`define SQC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqc check failed");
`endif

/* hdl/sqc_pkg.sv */
// shared constants, types and tables of the sprite quad corner setup block
package sqc_pkg;
    localparam int FRAC_BITS_DEF    = 8;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_W          = 24;
    localparam int ANGLE_IN_W       = 16;
    localparam int TRIG_W           = 32;
    localparam int TABLE_LEN        = 24;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;

    typedef logic [1:0] corner_t;
    localparam corner_t CORNER_TL = 2'd0;
    localparam corner_t CORNER_TR = 2'd1;
    localparam corner_t CORNER_BL = 2'd2;
    localparam corner_t CORNER_BR = 2'd3;

    // one placement after the front end: offsets and position kept exact
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W:0]   abs_w;
        logic signed [COORD_W:0]   abs_h;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
        logic                      rotate;
    } place_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    function automatic logic signed [TRIG_W-1:0] atan_turns(input int idx);
        logic signed [TRIG_W-1:0] r;
        case (idx)
            0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
            3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
            9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
            12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
            15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
            18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
            21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

/* hdl/sqc_cordic.sv */
// pipelined rotation-mode cordic, one iteration per stage, with stall
module sqc_cordic #(
    parameter int ANGLE_BITS   = sqc_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = sqc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [ANGLE_BITS-1:0]               angle,
    input  sqc_pkg::place_t                     in_place,
    output logic                                out_valid,
    output sqc_pkg::place_t                     out_place,
    output sqc_pkg::trig_t                      out_trig
);
    localparam int W = sqc_pkg::TRIG_W;
    localparam int N = CORDIC_STEPS;

    logic                 vld_reg  [N+1];
    logic signed [W:0]    x_reg    [N+1];
    logic signed [W:0]    y_reg    [N+1];
    logic signed [W:0]    z_reg    [N+1];
    logic [1:0]           quad_reg [N+1];
    sqc_pkg::place_t      pl_reg   [N+1];

    logic [W-1:0] turns32;
    assign turns32 = {angle, {(W-ANGLE_BITS){1'b0}}};

    always_comb
    begin
        vld_reg[0]  = in_valid;
        x_reg[0]    = (W+1)'(sqc_pkg::GAIN_Q30);
        y_reg[0]    = '0;
        z_reg[0]    = (W+1)'($signed({1'b0, turns32[W-3:0]}));
        quad_reg[0] = turns32[W-1:W-2];
        pl_reg[0]   = in_place;
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        logic signed [W:0] dx, dy, at;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        assign at = (W+1)'(sqc_pkg::atan_turns(i));
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][W])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                quad_reg[i+1] <= quad_reg[i];
                pl_reg[i+1]   <= pl_reg[i];
            end
        end
    end

    logic signed [W-1:0] xf, yf;
    assign xf = x_reg[N][W-1:0];
    assign yf = y_reg[N][W-1:0];

    always_comb
    begin
        case (quad_reg[N])
            2'd0:    begin out_trig.cos_v = xf;  out_trig.sin_v = yf;  end
            2'd1:    begin out_trig.cos_v = -yf; out_trig.sin_v = xf;  end
            2'd2:    begin out_trig.cos_v = -xf; out_trig.sin_v = -yf; end
            default: begin out_trig.cos_v = yf;  out_trig.sin_v = -xf; end
        endcase
    end
    assign out_valid = vld_reg[N];
    assign out_place = pl_reg[N];
endmodule

/* hdl/sqc_corner.sv */
// corner sequencer: four corners per placement, multiply, round, translate, saturate
module sqc_corner (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sqc_pkg::place_t       in_place,
    input  sqc_pkg::trig_t        in_trig,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [47:0]           out_data,
    output logic [2:0]            out_user,
    output logic                  out_last
);
    localparam int CW = sqc_pkg::COORD_W;
    localparam int TW = sqc_pkg::TRIG_W;

    // stage a: hold placement, step corners
    logic                 a_vld_reg;
    sqc_pkg::place_t      a_pl_reg;
    sqc_pkg::trig_t       a_tr_reg;
    sqc_pkg::corner_t     a_k_reg;
    // stage b: offsets
    logic                 b_vld_reg;
    logic signed [CW+1:0] b_a_reg, b_b_reg;
    sqc_pkg::place_t      b_pl_reg;
    sqc_pkg::trig_t       b_tr_reg;
    sqc_pkg::corner_t     b_k_reg;
    // stage c: products
    logic                 c_vld_reg;
    logic signed [CW+TW+1:0] c_p0_reg, c_p1_reg, c_p2_reg, c_p3_reg;
    logic signed [CW+1:0] c_a_reg, c_b_reg;
    sqc_pkg::place_t      c_pl_reg;
    sqc_pkg::corner_t     c_k_reg;
    // stage d: rotated coordinates
    logic                 d_vld_reg;
    logic signed [CW+3:0] d_rx_reg, d_ry_reg;
    sqc_pkg::place_t      d_pl_reg;
    sqc_pkg::corner_t     d_k_reg;
    // output register
    logic                 o_vld_reg;
    logic [47:0]          o_data_reg;
    sqc_pkg::corner_t     o_k_reg;

    logic en;
    assign en = !o_vld_reg || out_ready;
    assign in_ready = en && (!a_vld_reg || a_k_reg == sqc_pkg::CORNER_BR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0; a_k_reg <= sqc_pkg::CORNER_TL;
            b_vld_reg <= 1'b0; c_vld_reg <= 1'b0; d_vld_reg <= 1'b0; o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (in_valid && in_ready)
            begin
                a_vld_reg <= 1'b1; a_k_reg <= sqc_pkg::CORNER_TL;
            end
            else if (a_vld_reg && a_k_reg != sqc_pkg::CORNER_BR)
                a_k_reg <= a_k_reg + 2'd1;
            else
                a_vld_reg <= 1'b0;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            o_vld_reg <= d_vld_reg;
        end
    end

    logic signed [CW+3:0] rx_n, ry_n, sx, sy;
    logic signed [CW+TW+3:0] sum_x, sum_y;
    assign sum_x = (CW+TW+4)'(c_p0_reg) - (CW+TW+4)'(c_p1_reg) + (CW+TW+4)'(64'sd1 <<< 29);
    assign sum_y = (CW+TW+4)'(c_p2_reg) + (CW+TW+4)'(c_p3_reg) + (CW+TW+4)'(64'sd1 <<< 29);
    always_comb
    begin
        if (c_pl_reg.rotate)
        begin
            rx_n = (CW+4)'(sum_x >>> 30);
            ry_n = (CW+4)'(sum_y >>> 30);
        end
        else
        begin
            rx_n = (CW+4)'(c_a_reg);
            ry_n = (CW+4)'(c_b_reg);
        end
    end
    assign sx = d_rx_reg + (CW+4)'(d_pl_reg.pos_x);
    assign sy = d_ry_reg + (CW+4)'(d_pl_reg.pos_y);

    function automatic logic [CW-1:0] sat(input logic signed [CW+3:0] v);
        if (v > (CW+4)'(24'sh7FFFFF))       return 24'h7FFFFF;
        else if (v < -(CW+4)'(25'sh800000)) return 24'h800000;
        else                                return v[CW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_valid && in_ready)
            begin
                a_pl_reg <= in_place; a_tr_reg <= in_trig;
            end
            b_a_reg  <= -(CW+2)'(a_pl_reg.pivot_x)
                        + (a_k_reg[0] ? (CW+2)'(a_pl_reg.abs_w) : '0);
            b_b_reg  <= -(CW+2)'(a_pl_reg.pivot_y)
                        + (a_k_reg[1] ? (CW+2)'(a_pl_reg.abs_h) : '0);
            b_pl_reg <= a_pl_reg; b_tr_reg <= a_tr_reg; b_k_reg <= a_k_reg;
            c_p0_reg <= b_a_reg * b_tr_reg.cos_v;
            c_p1_reg <= b_b_reg * b_tr_reg.sin_v;
            c_p2_reg <= b_b_reg * b_tr_reg.cos_v;
            c_p3_reg <= b_a_reg * b_tr_reg.sin_v;
            c_a_reg  <= b_a_reg; c_b_reg <= b_b_reg;
            c_pl_reg <= b_pl_reg; c_k_reg <= b_k_reg;
            d_rx_reg <= rx_n; d_ry_reg <= ry_n;
            d_pl_reg <= c_pl_reg; d_k_reg <= c_k_reg;
            o_data_reg <= {sat(sy), sat(sx)};
            o_k_reg  <= d_k_reg;
        end
    end

    assign out_valid = o_vld_reg;
    assign out_data  = o_data_reg;
    assign out_last  = (o_k_reg == sqc_pkg::CORNER_BR);
    assign out_user  = {out_last, o_k_reg};
endmodule

/* hdl/sprite_quad_corner_setup_top.sv */
// top level of the rotated sprite quad corner setup block
// usage:
//   slave channel s_axis_*: one sprite placement per transaction, fields in
//   s_axis_tdata from bit 0: pos_x, pos_y, size_w, size_h, pivot_x, pivot_y,
//   turn_angle (160 bits). master channel m_axis_*: four corner transactions
//   per sprite in the order top-left, top-right, bottom-left, bottom-right;
//   tdata holds corner_x then corner_y, tuser holds corner_index then
//   last_corner, and tlast marks the fourth corner as well.
// sprite intake: the corner sequencer shares one set of four multipliers over the
//   four corners, so it takes a new sprite only when idle or on the last corner of the one before.
// pipeline: the input register feeds CORDIC_STEPS cordic stages, one per
//   iteration, which give sine and cosine; five corner stages (a, b, c, d
//   and the output register) follow before the first corner shows.
// zero angle bypasses the rotation and gives exact corners.
// reset clears every valid bit; no transaction is in flight afterwards.
// a stall on the master side freezes the corner stages; the front holds while its
//   valid output waits, so nothing is lost or repeated, and s_axis_tready drops meanwhile.
module sprite_quad_corner_setup_top #(
    parameter int ANGLE_BITS   = sqc_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = sqc_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // pos_x, pos_y, size_w, size_h, pivot_x, pivot_y, turn_angle
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // corner_x, corner_y
    output logic [2:0]   m_axis_tuser,  // corner_index, last_corner
    output logic         m_axis_tlast
);
    localparam int CW = sqc_pkg::COORD_W;

    // input register stage
    logic            i_vld_reg;
    logic [159:0]    i_data_reg;
    logic            cor_en, cor_vld, seq_ready;
    sqc_pkg::place_t pl_in, pl_out;
    sqc_pkg::trig_t  trig;
    logic signed [CW-1:0] w_in, h_in;

    // whole front stalls when the sequencer can not take the cordic output
    assign cor_en        = !cor_vld || seq_ready;
    assign s_axis_tready = cor_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_vld_reg <= 1'b0;
        else if (cor_en)
            i_vld_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (cor_en)
            i_data_reg <= s_axis_tdata;
    end

    assign w_in = i_data_reg[71:48];
    assign h_in = i_data_reg[95:72];
    always_comb
    begin
        pl_in.pos_x   = i_data_reg[23:0];
        pl_in.pos_y   = i_data_reg[47:24];
        pl_in.abs_w   = w_in[CW-1] ? -(CW+1)'(w_in) : (CW+1)'(w_in);
        pl_in.abs_h   = h_in[CW-1] ? -(CW+1)'(h_in) : (CW+1)'(h_in);
        pl_in.pivot_x = i_data_reg[119:96];
        pl_in.pivot_y = i_data_reg[143:120];
        pl_in.rotate  = i_data_reg[144 +: ANGLE_BITS] != '0;
    end

    sqc_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk, .rst_n, .en(cor_en), .in_valid(i_vld_reg),
        .angle(i_data_reg[144 +: ANGLE_BITS]), .in_place(pl_in),
        .out_valid(cor_vld), .out_place(pl_out), .out_trig(trig)
    );

    sqc_corner u_corner (
        .clk, .rst_n, .in_valid(cor_vld), .in_ready(seq_ready),
        .in_place(pl_out), .in_trig(trig),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast)
    );
endmodule

/* hdl/sqc_checker.sv */
// port-level checks of the sprite quad corner setup block
`include "sprite_quad_corner_setup_top_defines.svh"
module sqc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    sqc_pkg::corner_t idx;
    logic             acc_mid;
    logic             stall;
    assign idx     = m_axis_tuser[1:0];
    assign acc_mid = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign stall   = m_axis_tvalid && !m_axis_tready;

    `SQC_ASSERT_IMP(last_matches_index, m_axis_tvalid, m_axis_tlast == (idx == sqc_pkg::CORNER_BR))
    `SQC_ASSERT_IMP(user_flag_matches_last, m_axis_tvalid, m_axis_tuser[2] == m_axis_tlast)
    `SQC_ASSERT_NEXT(index_steps, acc_mid, m_axis_tvalid && idx == $past(idx) + 2'd1)
    `SQC_ASSERT_NEXT(stall_holds, stall, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind sprite_quad_corner_setup_top sqc_checker u_sqc_checker (.*);

/* tb/sv/sprite_quad_corner_setup_top_tb.sv */
// testbench for the rotated sprite quad corner setup block
`timescale 1ns / 100ps

module sprite_quad_corner_setup_top_tb;

    // one sprite placement as it travels on the slave channel
    typedef struct {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] size_w;
        logic signed [23:0] size_h;
        logic signed [23:0] pivot_x;
        logic signed [23:0] pivot_y;
        logic [15:0]        turn_angle;
    } sprite_t;

    // one expected corner
    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        sqc_pkg::corner_t   idx;
        logic               last;
    } corner_exp_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;  // pos_x, pos_y, size_w, size_h, pivot_x, pivot_y, turn_angle
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;  // corner_x, corner_y
    logic [2:0]   m_axis_tuser;  // corner_index, last_corner
    logic         m_axis_tlast;

    int  err_count;
    bit  hold_off;
    int  n_sprites;
    int  n_corners;
    int  n_rotated;
    int  n_saturated;

    // scoreboard: predicts the four corners of each sprite and checks them in order
    class corner_board;
        corner_exp_t pending[$];

        // cordic sine and cosine in q1.30 from a 32 bit turn value
        function automatic void sin_cos(input logic [31:0] turns,
                                        output longint c, output longint s);
            longint x, y, z, dx, dy;
            logic [1:0] quad;
            quad = turns[31:30];
            z = longint'(turns[29:0]);
            x = 652032874;
            y = 0;
            for (int i = 0; i < sqc_pkg::CORDIC_STEPS_DEF; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= longint'(sqc_pkg::atan_turns(i));
                end
                else
                begin
                    x += dx; y -= dy; z += longint'(sqc_pkg::atan_turns(i));
                end
            end
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function automatic longint clip24(input longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void note_sprite(input sprite_t sp);
            longint w, h, c, s, a, b, rx, ry, fx, fy;
            logic [31:0] turns;
            corner_exp_t e;
            w = sp.size_w; if (w < 0) w = -w;
            h = sp.size_h; if (h < 0) h = -h;
            turns = {sp.turn_angle, 16'h0};
            c = 0; s = 0;
            if (sp.turn_angle != 0)
            begin
                sin_cos(turns, c, s);
                n_rotated++;
            end
            for (int k = 0; k < 4; k++)
            begin
                a = -longint'(sp.pivot_x) + ((k & 1) ? w : 0);
                b = -longint'(sp.pivot_y) + ((k & 2) ? h : 0);
                rx = a; ry = b;
                if (sp.turn_angle != 0)
                begin
                    rx = (a * c - b * s + (longint'(1) << 29)) >>> 30;
                    ry = (b * c + a * s + (longint'(1) << 29)) >>> 30;
                end
                fx = rx + sp.pos_x;
                fy = ry + sp.pos_y;
                if (fx != clip24(fx) || fy != clip24(fy)) n_saturated++;
                e.cx = 24'(clip24(fx));
                e.cy = 24'(clip24(fy));
                e.idx = sqc_pkg::corner_t'(k);
                e.last = (k == 3);
                pending.push_back(e);
            end
        endfunction

        task check_corner(input logic [47:0] d, input logic [2:0] u,
                          input logic tl);
            corner_exp_t e;
            if (pending.size() == 0)
            begin
                report_err("corner with no sprite pending");
                return;
            end
            e = pending.pop_front();
            if (d[23:0] !== e.cx)
                report_err($sformatf("corner %0d x got %0d want %0d", e.idx,
                                     $signed(d[23:0]), e.cx));
            if (d[47:24] !== e.cy)
                report_err($sformatf("corner %0d y got %0d want %0d", e.idx,
                                     $signed(d[47:24]), e.cy));
            if (u[1:0] !== e.idx)
                report_err($sformatf("corner index got %0d want %0d", u[1:0], e.idx));
            if (u[2] !== e.last || tl !== e.last)
                report_err($sformatf("last flag wrong on corner %0d", e.idx));
        endtask
    endclass

    corner_board board;

    sprite_quad_corner_setup_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // a mismatch prints one line and is counted
    task automatic report_err(input string msg);
        err_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // random 24 bit value, biased towards extremes and small numbers
    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return 24'($signed($urandom_range(0, 16383)) - 8192);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'($urandom_range(0, 3)) << 14;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // present one sprite and hold it until the block takes it
    task automatic send_sprite(input sprite_t sp);
        s_axis_tdata  <= {sp.turn_angle, sp.pivot_y, sp.pivot_x, sp.size_h,
                          sp.size_w, sp.pos_y, sp.pos_x};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        board.note_sprite(sp);
        n_sprites++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    function automatic sprite_t make_sprite(input logic [23:0] px, py, w, h, cx, cy,
                                            input logic [15:0] ang);
        sprite_t sp;
        sp.pos_x = px; sp.pos_y = py; sp.size_w = w; sp.size_h = h;
        sp.pivot_x = cx; sp.pivot_y = cy; sp.turn_angle = ang;
        return sp;
    endfunction

    function automatic sprite_t rand_sprite();
        return make_sprite(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_angle());
    endfunction

    // receiver: stalls on its own pattern, checks each accepted corner
    initial
    begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_corner(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                n_corners++;
            end
            @(negedge clk);
            phase++;
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if ((phase / 64) % 3 == 0)
                m_axis_tready <= 1'b1;              // stretch with no stalls
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // long receiver hold-off, counted in cycles in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (n_sprites == 60);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("timeout at %0t", $time);
        $display("sprite_quad_corner_setup_top_tb: errors");
        $finish;
    end

    initial
    begin
        sprite_t sp;
        int burst;
        board = new();
        err_count = 0; n_sprites = 0; n_corners = 0; n_rotated = 0; n_saturated = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero angle, quarter turns, extremes, saturation, odd angles
        send_sprite(make_sprite(24'd1000, 24'd2000, 24'd256, 24'd512, 24'd0, 24'd0, 16'h0));
        send_sprite(make_sprite(24'd0, 24'd0, -24'sd256, -24'sd512, 24'd128, 24'd64, 16'h0));
        send_sprite(make_sprite(24'd0, 24'd0, 24'd256, 24'd256, 24'd128, 24'd128, 16'h4000));
        send_sprite(make_sprite(24'd0, 24'd0, 24'd256, 24'd256, 24'd128, 24'd128, 16'h8000));
        send_sprite(make_sprite(24'd0, 24'd0, 24'd256, 24'd256, 24'd128, 24'd128, 16'hC000));
        send_sprite(make_sprite(24'd0, 24'd0, 24'd256, 24'd256, 24'd0, 24'd0, 16'h2000));
        send_sprite(make_sprite(24'd0, 24'd0, 24'd256, 24'd256, 24'd0, 24'd0, 16'h0001));
        send_sprite(make_sprite(24'd0, 24'd0, 24'd256, 24'd256, 24'd0, 24'd0, 16'hFFFF));
        // most negative size used unwrapped
        send_sprite(make_sprite(24'd0, 24'd0, 24'h800000, 24'h800000, 24'd0, 24'd0, 16'h0));
        send_sprite(make_sprite(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                                24'h800000, 24'h800000, 16'h0));
        // saturation both ways
        send_sprite(make_sprite(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                24'h800000, 24'h800000, 16'h0));
        send_sprite(make_sprite(24'h800000, 24'h800000, 24'h0, 24'h0,
                                24'h7FFFFF, 24'h7FFFFF, 16'h0));
        send_sprite(make_sprite(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                                24'h7FFFFF, 24'h800000, 16'h6123));
        send_sprite(make_sprite(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                24'hFFFFFF, 24'hFFFFFF, 16'hFFFF));
        send_sprite(make_sprite(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                                24'h555555, 24'hAAAAAA, 16'h5555));
        send_sprite(make_sprite(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                                24'hAAAAAA, 24'h555555, 16'hAAAA));
        // sender pause until all corners have come back
        wait_drained();

        // random: bursts of random length with random gaps
        while (n_sprites < 226)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++)
            begin
                sp = rand_sprite();
                send_sprite(sp);
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 15));
            if (n_sprites > 150 && n_sprites < 160)
                wait_drained();
        end

        wait_drained();
        repeat (sqc_pkg::CORDIC_STEPS_DEF + 20) @(negedge clk);
        $display("run covered %0d sprites, %0d corners, %0d rotated, %0d saturated corners",
                 n_sprites, n_corners, n_rotated, n_saturated);
        $display("stimulus included quarter turns, size and position extremes and stalls");
        if (err_count == 0 && board.pending.size() == 0)
            $display("sprite_quad_corner_setup_top_tb: clean");
        else
            $display("sprite_quad_corner_setup_top_tb: errors");
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/sqc_pkg.sv
hdl/sqc_cordic.sv
hdl/sqc_corner.sv
hdl/sprite_quad_corner_setup_top.sv
hdl/sqc_checker.sv
tb/sv/sprite_quad_corner_setup_top_tb.sv
